// ----- design/thpl_pkg.sv -----
`default_nettype none

package thpl_pkg;

    localparam int HistDepth = 1024;
    localparam int IdxW      = (HistDepth > 1) ? $clog2(HistDepth) : 1;
    localparam int CntW      = IdxW + 1;
    localparam int TimeW     = 48;
    localparam int PosW      = 32;
    localparam int QuatW     = 16;
    localparam int DelayW    = 25;
    localparam int QueryW    = TimeW + 2;
    localparam int StatusW   = 3;

    localparam logic [CntW-1:0] DepthC = CntW'(HistDepth);

    typedef enum logic {
        OP_RECORD = 1'b0,
        OP_LOOKUP = 1'b1
    } t_op;

    typedef enum logic [StatusW-1:0] {
        ST_EMPTY  = 3'd0,
        ST_FUTURE = 3'd1,
        ST_NEWEST = 3'd2,
        ST_OLDEST = 3'd3,
        ST_SPAN   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_FETCH,
        S_SCAN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic        [TimeW-1:0] stamp;
        logic signed [PosW-1:0]  x;
        logic signed [PosW-1:0]  y;
        logic signed [PosW-1:0]  z;
        logic signed [QuatW-1:0] w;
        logic signed [QuatW-1:0] qx;
        logic signed [QuatW-1:0] qy;
        logic signed [QuatW-1:0] qz;
    } t_entry;

    localparam int EntryW = $bits(t_entry);

    typedef struct packed {
        t_status status;
        t_entry  entry;
    } t_result;

endpackage

`default_nettype wire

// ----- design/timestamped_pose_history_lookup.sv -----
// Pose history with delayed-time lookup. Poses (Q16.16 position, Q2.14
// quaternion) are kept in a ring of thpl_pkg::HistDepth entries held in one
// synchronous RAM; a record request stamps the pose with i_time_now, appends
// it when accepted and produces no result, overwriting the oldest entry once
// the ring is full. A lookup request forms query = i_time_now - lookup_delay
// and returns one result: empty status on an empty ring, the newest entry for
// a future query or one at or after the newest stamp, the oldest entry for a
// query before the oldest stamp, otherwise the entry just before the first
// stamp later than the query. An empty ring goes straight to the result, the
// newest entry is fetched with a single read, and otherwise the search reads
// one stored stamp per cycle through the RAM read port, from the oldest on.
// A finished result sits in an output register, so a new request is taken
// while it waits; lookup_delay is written through i_cfg_wr_en/i_cfg_wr_data,
// and the user must do so only while no lookup is in flight: the block itself
// does not enforce this. No clearing pass follows reset.
`default_nettype none

module timestamped_pose_history_lookup (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic signed [thpl_pkg::DelayW-1:0]  i_cfg_wr_data,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic                                i_operation,
    input  wire logic        [thpl_pkg::TimeW-1:0]   i_time_now,
    input  wire logic signed [thpl_pkg::PosW-1:0]    i_position_x,
    input  wire logic signed [thpl_pkg::PosW-1:0]    i_position_y,
    input  wire logic signed [thpl_pkg::PosW-1:0]    i_position_z,
    input  wire logic signed [thpl_pkg::QuatW-1:0]   i_rotation_w,
    input  wire logic signed [thpl_pkg::QuatW-1:0]   i_rotation_x,
    input  wire logic signed [thpl_pkg::QuatW-1:0]   i_rotation_y,
    input  wire logic signed [thpl_pkg::QuatW-1:0]   i_rotation_z,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic             [thpl_pkg::StatusW-1:0] o_status,
    output logic signed      [thpl_pkg::PosW-1:0]    o_found_x,
    output logic signed      [thpl_pkg::PosW-1:0]    o_found_y,
    output logic signed      [thpl_pkg::PosW-1:0]    o_found_z,
    output logic signed      [thpl_pkg::QuatW-1:0]   o_found_w,
    output logic signed      [thpl_pkg::QuatW-1:0]   o_found_qx,
    output logic signed      [thpl_pkg::QuatW-1:0]   o_found_qy,
    output logic signed      [thpl_pkg::QuatW-1:0]   o_found_qz,
    output logic             [thpl_pkg::TimeW-1:0]   o_found_stamp
);

    import thpl_pkg::*;

    logic signed [DelayW-1:0] r_delay;
    logic                     r_out_valid;
    t_result                  r_out;

    t_entry                   w_in_entry;
    t_entry                   w_rd_data;
    logic                     w_wr_en;
    logic [IdxW-1:0]          w_wr_addr;
    logic                     w_rd_en;
    logic [IdxW-1:0]          w_rd_addr;
    logic                     w_res_valid;
    logic                     w_res_ready;
    t_result                  w_res;

    always_comb begin
        w_in_entry.stamp = i_time_now;
        w_in_entry.x     = i_position_x;
        w_in_entry.y     = i_position_y;
        w_in_entry.z     = i_position_z;
        w_in_entry.w     = i_rotation_w;
        w_in_entry.qx    = i_rotation_x;
        w_in_entry.qy    = i_rotation_y;
        w_in_entry.qz    = i_rotation_z;
    end

    thpl_ram #(
        .Width (EntryW),
        .Depth (HistDepth)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_in_entry),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    thpl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_operation),
        .i_entry     (w_in_entry),
        .i_delay     (r_delay),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    assign w_res_ready = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_delay <= i_cfg_wr_data;
            end
            if (w_res_valid && w_res_ready) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out.status;
    assign o_found_x     = r_out.entry.x;
    assign o_found_y     = r_out.entry.y;
    assign o_found_z     = r_out.entry.z;
    assign o_found_w     = r_out.entry.w;
    assign o_found_qx    = r_out.entry.qx;
    assign o_found_qy    = r_out.entry.qy;
    assign o_found_qz    = r_out.entry.qz;
    assign o_found_stamp = r_out.entry.stamp;

`ifndef SYNTH
    a_ready_not_while_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_res_valid && o_ready))
        else $error("request taken while a result is pending in the sequencer");

    a_lookup_blocks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_operation == OP_LOOKUP) |=> !o_ready)
        else $error("lookup request did not start the search");

    a_record_keeps_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_operation == OP_RECORD) |=> o_ready)
        else $error("record request stalled the input");

    a_empty_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_EMPTY) |-> (o_found_stamp == '0 && o_found_x == '0))
        else $error("empty result carries a nonzero entry");
`endif

endmodule

`default_nettype wire

// ----- design/thpl_ram.sv -----
`default_nettype none

module thpl_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_wr_en,
    input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] i_wr_addr,
    input  wire logic [Width-1:0]                          i_wr_data,
    input  wire logic                                      i_rd_en,
    input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] i_rd_addr,
    output logic      [Width-1:0]                          o_rd_data
);

    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- design/thpl_ctrl.sv -----
`default_nettype none

module thpl_ctrl (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic                                i_op,
    input  wire thpl_pkg::t_entry                    i_entry,
    input  wire logic signed [thpl_pkg::DelayW-1:0]  i_delay,
    output logic                                     o_wr_en,
    output logic             [thpl_pkg::IdxW-1:0]    o_wr_addr,
    output logic                                     o_rd_en,
    output logic             [thpl_pkg::IdxW-1:0]    o_rd_addr,
    input  wire thpl_pkg::t_entry                    i_rd_data,
    output logic                                     o_res_valid,
    input  wire logic                                i_res_ready,
    output thpl_pkg::t_result                        o_res
);

    import thpl_pkg::*;

    t_state                    r_state, n_state;
    logic [IdxW-1:0]           r_oldest, n_oldest;
    logic [CntW-1:0]           r_count, n_count;
    logic [IdxW-1:0]           r_newest, n_newest;
    logic [TimeW-1:0]          r_newest_stamp, n_newest_stamp;
    logic signed [QueryW-1:0]  r_query, n_query;
    logic                      r_future, n_future;
    logic [CntW-1:0]           r_k, n_k;
    t_entry                    r_prev, n_prev;
    t_result                   r_res, n_res;

    logic                      w_idle;
    logic                      w_accept;
    logic                      w_record;
    logic                      w_full;
    logic [IdxW-1:0]           w_wr_slot;
    logic [IdxW-1:0]           w_oldest_inc;
    logic signed [QueryW-1:0]  w_newest_s;
    logic signed [QueryW-1:0]  w_rd_stamp_s;
    logic                      w_ge_newest;
    logic                      w_hit;
    logic                      w_last;

    function automatic logic [IdxW-1:0] slot_of(input logic [IdxW-1:0] base,
                                                 input logic [CntW-1:0] k);
        logic [CntW-1:0] sum;
        sum = {1'b0, base} + k;
        if (sum >= DepthC) begin
            sum = sum - DepthC;
        end
        return sum[IdxW-1:0];
    endfunction

    assign w_idle       = (r_state == S_IDLE);
    assign w_accept     = i_valid && w_idle;
    assign w_record     = (t_op'(i_op) == OP_RECORD);
    assign w_full       = (r_count == DepthC);
    assign w_oldest_inc = (r_oldest == IdxW'(HistDepth - 1)) ? '0 : r_oldest + 1'b1;
    assign w_wr_slot    = w_full ? r_oldest : slot_of(r_oldest, r_count);
    assign w_newest_s   = $signed({2'b00, r_newest_stamp});
    assign w_rd_stamp_s = $signed({2'b00, i_rd_data.stamp});
    assign w_ge_newest  = (r_query >= w_newest_s);
    assign w_hit        = (w_rd_stamp_s > r_query);
    assign w_last       = (r_k == r_count - 1'b1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && !w_record) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_count == '0) begin
                    n_state = S_EMIT;
                end else if (r_future || w_ge_newest) begin
                    n_state = S_FETCH;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_FETCH: begin
                n_state = S_EMIT;
            end
            S_SCAN: begin
                if (w_hit || w_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready     = w_idle;
        o_wr_en     = w_accept && w_record;
        o_wr_addr   = w_wr_slot;
        o_rd_en     = 1'b0;
        o_rd_addr   = r_oldest;
        o_res_valid = 1'b0;
        o_res       = r_res;
        case (r_state)
            S_CHECK: begin
                o_rd_en   = 1'b1;
                o_rd_addr = (r_future || w_ge_newest) ? r_newest : r_oldest;
            end
            S_SCAN: begin
                o_rd_en   = 1'b1;
                o_rd_addr = slot_of(r_oldest, r_k + 1'b1);
            end
            S_EMIT: begin
                o_res_valid = 1'b1;
            end
            default: begin
                o_rd_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_oldest       = r_oldest;
        n_count        = r_count;
        n_newest       = r_newest;
        n_newest_stamp = r_newest_stamp;
        n_query        = r_query;
        n_future       = r_future;
        n_k            = r_k;
        n_prev         = r_prev;
        n_res          = r_res;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_record) begin
                        n_newest       = w_wr_slot;
                        n_newest_stamp = i_entry.stamp;
                        if (w_full) begin
                            n_oldest = w_oldest_inc;
                        end else begin
                            n_count = r_count + 1'b1;
                        end
                    end else begin
                        n_query  = $signed({2'b00, i_entry.stamp})
                                 - $signed({{(QueryW - DelayW){i_delay[DelayW-1]}}, i_delay});
                        n_future = i_delay[DelayW-1];
                    end
                end
            end
            S_CHECK: begin
                n_k = '0;
                if (r_count == '0) begin
                    n_res.status = ST_EMPTY;
                    n_res.entry  = '0;
                end else if (r_future) begin
                    n_res.status = ST_FUTURE;
                end else if (w_ge_newest) begin
                    n_res.status = ST_NEWEST;
                end
            end
            S_FETCH: begin
                n_res.entry = i_rd_data;
            end
            S_SCAN: begin
                if (w_hit) begin
                    if (r_k == '0) begin
                        n_res.status = ST_OLDEST;
                        n_res.entry  = i_rd_data;
                    end else begin
                        n_res.status = ST_SPAN;
                        n_res.entry  = r_prev;
                    end
                end else if (w_last) begin
                    n_res.status = ST_SPAN;
                    n_res.entry  = i_rd_data;
                end else begin
                    n_prev = i_rd_data;
                    n_k    = r_k + 1'b1;
                end
            end
            default: begin
                n_k = r_k;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_oldest <= '0;
            r_count  <= '0;
            r_newest <= '0;
        end else begin
            r_state  <= n_state;
            r_oldest <= n_oldest;
            r_count  <= n_count;
            r_newest <= n_newest;
        end
    end

    always_ff @(posedge i_clk) begin
        r_newest_stamp <= n_newest_stamp;
        r_query        <= n_query;
        r_future       <= n_future;
        r_k            <= n_k;
        r_prev         <= n_prev;
        r_res          <= n_res;
    end

endmodule

`default_nettype wire

// ----- test/timestamped_pose_history_lookup_tb.sv -----
`timescale 1ns / 100ps

module timestamped_pose_history_lookup_tb;

    import thpl_pkg::*;

    localparam int  ClkHalf      = 2;
    localparam int  ResetCycles  = 11;
    localparam int  SettleCycles = HistDepth + 8;
    localparam int  HoldCycles   = 3000;
    localparam longint CycleLimit = 64'd8_000_000;
    localparam logic [TimeW-1:0] TimeMax = '1;
    localparam int  DelayMax     = 10_000_000;
    localparam int  MaxPrinted   = 100;

    typedef struct packed {
        t_op                     op;
        logic        [TimeW-1:0] time_now;
        logic signed [PosW-1:0]  px;
        logic signed [PosW-1:0]  py;
        logic signed [PosW-1:0]  pz;
        logic signed [QuatW-1:0] rw;
        logic signed [QuatW-1:0] rx;
        logic signed [QuatW-1:0] ry;
        logic signed [QuatW-1:0] rz;
    } t_pose_req;

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_cfg_wr_en   = 1'b0;
    logic signed [DelayW-1:0] i_cfg_wr_data = '0;
    logic                     i_valid       = 1'b0;
    logic                     o_ready;
    logic                     i_operation   = 1'b0;
    logic        [TimeW-1:0]  i_time_now    = '0;
    logic signed [PosW-1:0]   i_position_x  = '0;
    logic signed [PosW-1:0]   i_position_y  = '0;
    logic signed [PosW-1:0]   i_position_z  = '0;
    logic signed [QuatW-1:0]  i_rotation_w  = '0;
    logic signed [QuatW-1:0]  i_rotation_x  = '0;
    logic signed [QuatW-1:0]  i_rotation_y  = '0;
    logic signed [QuatW-1:0]  i_rotation_z  = '0;
    logic                     o_valid;
    logic                     i_ready       = 1'b0;
    logic        [StatusW-1:0] o_status;
    logic signed [PosW-1:0]   o_found_x;
    logic signed [PosW-1:0]   o_found_y;
    logic signed [PosW-1:0]   o_found_z;
    logic signed [QuatW-1:0]  o_found_w;
    logic signed [QuatW-1:0]  o_found_qx;
    logic signed [QuatW-1:0]  o_found_qy;
    logic signed [QuatW-1:0]  o_found_qz;
    logic        [TimeW-1:0]  o_found_stamp;

    // pose ring mirror
    t_entry                   pose_ring [HistDepth];
    int                       ring_oldest = 0;
    int                       ring_count  = 0;
    logic signed [DelayW-1:0] delay_setting = '0;

    t_pose_req pending_requests [$];
    t_result   expected_lookups [$];
    t_pose_req offer;

    logic [TimeW-1:0] clock_us = '0;
    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    logic   stall_go       = 1'b0;
    int     hold_count     = 0;
    longint cycle_count    = 0;
    int     mismatches     = 0;
    int     requests_taken = 0;
    int     records_taken  = 0;
    int     results_seen   = 0;
    int     status_seen [5];

    timestamped_pose_history_lookup u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_operation   (i_operation),
        .i_time_now    (i_time_now),
        .i_position_x  (i_position_x),
        .i_position_y  (i_position_y),
        .i_position_z  (i_position_z),
        .i_rotation_w  (i_rotation_w),
        .i_rotation_x  (i_rotation_x),
        .i_rotation_y  (i_rotation_y),
        .i_rotation_z  (i_rotation_z),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_found_x     (o_found_x),
        .o_found_y     (o_found_y),
        .o_found_z     (o_found_z),
        .o_found_w     (o_found_w),
        .o_found_qx    (o_found_qx),
        .o_found_qy    (o_found_qy),
        .o_found_qz    (o_found_qz),
        .o_found_stamp (o_found_stamp)
    );

    always #ClkHalf i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        if (mismatches < MaxPrinted) begin
            $display("[%0t] MISMATCH: %s", $time, msg);
        end
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            report_mismatch($sformatf("lookup %0d %s: expected 0x%0h got 0x%0h",
                                      results_seen, name, want, got));
        end
    endtask

    // Applies one accepted request to the ring mirror; lookups queue a result.
    task automatic apply_pose_request(input t_pose_req req);
        t_entry                   fresh;
        t_result                  res;
        logic signed [QueryW-1:0] now_s;
        logic signed [QueryW-1:0] query;
        int                       newest;
        int                       pick;
        int                       k;
        logic                     hit;
        fresh.stamp = req.time_now;
        fresh.x     = req.px;
        fresh.y     = req.py;
        fresh.z     = req.pz;
        fresh.w     = req.rw;
        fresh.qx    = req.rx;
        fresh.qy    = req.ry;
        fresh.qz    = req.rz;
        requests_taken++;
        if (req.op == OP_RECORD) begin
            records_taken++;
            if (ring_count == HistDepth) begin
                pose_ring[ring_oldest] = fresh;
                ring_oldest = (ring_oldest + 1) % HistDepth;
            end else begin
                pose_ring[(ring_oldest + ring_count) % HistDepth] = fresh;
                ring_count++;
            end
        end else begin
            if (ring_count == 0) begin
                res.status = ST_EMPTY;
                res.entry  = '0;
            end else begin
                now_s  = $signed({2'b00, req.time_now});
                query  = now_s - {{(QueryW-DelayW){delay_setting[DelayW-1]}}, delay_setting};
                newest = (ring_oldest + ring_count - 1) % HistDepth;
                if (query > now_s) begin
                    res.status = ST_FUTURE;
                    res.entry  = pose_ring[newest];
                end else if (query >= $signed({2'b00, pose_ring[newest].stamp})) begin
                    res.status = ST_NEWEST;
                    res.entry  = pose_ring[newest];
                end else if (query < $signed({2'b00, pose_ring[ring_oldest].stamp})) begin
                    res.status = ST_OLDEST;
                    res.entry  = pose_ring[ring_oldest];
                end else begin
                    // walk from oldest; keep the entry before the first later stamp
                    hit  = 1'b0;
                    pick = newest;
                    for (k = 1; k < ring_count && !hit; k++) begin
                        if ($signed({2'b00, pose_ring[(ring_oldest + k) % HistDepth].stamp})
                                > query) begin
                            hit  = 1'b1;
                            pick = (ring_oldest + k - 1) % HistDepth;
                        end
                    end
                    res.status = ST_SPAN;
                    res.entry  = pose_ring[pick];
                end
            end
            expected_lookups = {expected_lookups, res};
        end
    endtask

    task automatic check_lookup_result();
        t_result want;
        if (expected_lookups.size() == 0) begin
            report_mismatch($sformatf("result with no lookup pending, status %0d", o_status));
        end else begin
            want = expected_lookups.pop_front();
            status_seen[want.status]++;
            check_field("status", 64'(want.status), 64'(o_status));
            check_field("found_x", 64'(want.entry.x), 64'(o_found_x));
            check_field("found_y", 64'(want.entry.y), 64'(o_found_y));
            check_field("found_z", 64'(want.entry.z), 64'(o_found_z));
            check_field("found_w", 64'(want.entry.w), 64'(o_found_w));
            check_field("found_qx", 64'(want.entry.qx), 64'(o_found_qx));
            check_field("found_qy", 64'(want.entry.qy), 64'(o_found_qy));
            check_field("found_qz", 64'(want.entry.qz), 64'(o_found_qz));
            check_field("found_stamp", 64'(want.entry.stamp), 64'(o_found_stamp));
        end
        results_seen++;
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                apply_pose_request(offer);
            end
            if (!i_valid || o_ready) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    offer = pending_requests.pop_front();
                    i_valid      <= 1'b1;
                    i_operation  <= offer.op;
                    i_time_now   <= offer.time_now;
                    i_position_x <= offer.px;
                    i_position_y <= offer.py;
                    i_position_z <= offer.pz;
                    i_rotation_w <= offer.rw;
                    i_rotation_x <= offer.rx;
                    i_rotation_y <= offer.ry;
                    i_rotation_z <= offer.rz;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                check_lookup_result();
            end
            i_ready <= !stall_go && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (stall_go) begin
            hold_count <= hold_count + 1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles, %0d lookups outstanding",
                     cycle_count, expected_lookups.size());
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic signed [QuatW-1:0] rand_quat();
        int q;
        q = $urandom_range(32768);
        return QuatW'(q - 16384);
    endfunction

    task automatic queue_pose(input t_op op, input logic [TimeW-1:0] t,
                              input logic signed [PosW-1:0] x, input logic signed [PosW-1:0] y,
                              input logic signed [PosW-1:0] z,
                              input logic signed [QuatW-1:0] w,
                              input logic signed [QuatW-1:0] qx,
                              input logic signed [QuatW-1:0] qy,
                              input logic signed [QuatW-1:0] qz);
        t_pose_req req;
        req.op       = op;
        req.time_now = t;
        req.px       = x;
        req.py       = y;
        req.pz       = z;
        req.rw       = w;
        req.rx       = qx;
        req.ry       = qy;
        req.rz       = qz;
        pending_requests = {pending_requests, req};
    endtask

    task automatic queue_random_pose(input t_op op, input logic [TimeW-1:0] t);
        queue_pose(op, t, $urandom, $urandom, $urandom,
                   rand_quat(), rand_quat(), rand_quat(), rand_quat());
    endtask

    // mostly forward time; a few repeated stamps and backward steps as noise
    task automatic queue_random_requests(input int count, input int step_max,
                                         input int lookup_pct);
        int n;
        int roll;
        for (n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < 5) begin
                if (clock_us > TimeW'(step_max)) begin
                    clock_us = clock_us - $urandom_range(step_max);
                end
            end else if (roll >= 12) begin
                clock_us = clock_us + $urandom_range(step_max);
            end
            queue_random_pose(($urandom_range(99) < lookup_pct) ? OP_LOOKUP : OP_RECORD,
                              clock_us);
        end
    endtask

    task automatic jump_time_base(input logic [2:0] top);
        clock_us = {top, 1'b0, 44'({$urandom, $urandom})};
    endtask

    task automatic wait_for_results();
        while (pending_requests.size() != 0 || i_valid || expected_lookups.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic drain_and_settle();
        wait_for_results();
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    task automatic write_delay(input int value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= DelayW'(value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        delay_setting  = DelayW'(value);
    endtask

    task automatic set_idle(input int send_pct, input int recv_pct);
        @(negedge i_clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic start_phase(input int delay, input int send_pct, input int recv_pct);
        drain_and_settle();
        write_delay(delay);
        set_idle(send_pct, recv_pct);
    endtask

    initial begin
        int hold_start;
        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_idle(0, 0);

        // empty ring, extreme payloads, lookup equal to newest stamp
        queue_random_pose(OP_LOOKUP, 0);
        queue_pose(OP_LOOKUP, 5, 32'h7fffffff, 32'h80000000, 0, 16384, -16384, 0, -1);
        queue_pose(OP_RECORD, 100, 32'h7fffffff, 32'h80000000, 0, 16384, -16384, 0, -1);
        queue_random_pose(OP_LOOKUP, 100);
        queue_pose(OP_RECORD, 200, 32'h80000000, 32'h7fffffff, -1, -16384, 16384, 1, 0);
        queue_random_pose(OP_RECORD, 200);
        queue_random_pose(OP_RECORD, 300);
        queue_random_pose(OP_LOOKUP, 350);

        // largest delay: query below zero, before oldest, inside span, at newest
        start_phase(DelayMax, 0, 0);
        queue_random_pose(OP_LOOKUP, 400);
        queue_random_pose(OP_LOOKUP, 10_000_099);
        queue_random_pose(OP_LOOKUP, 10_000_100);
        queue_random_pose(OP_LOOKUP, 10_000_200);
        queue_random_pose(OP_LOOKUP, 10_000_250);
        queue_random_pose(OP_LOOKUP, 10_000_300);

        // most negative delay: query in the future
        start_phase(-DelayMax, 0, 0);
        queue_random_pose(OP_LOOKUP, 10_000_400);

        // time going backwards between records
        start_phase(0, 0, 0);
        queue_random_pose(OP_RECORD, 50);
        queue_random_pose(OP_RECORD, 250);
        queue_random_pose(OP_LOOKUP, 240);
        queue_random_pose(OP_LOOKUP, 250);
        clock_us = 250;

        start_phase(1500, 0, 0);
        queue_random_requests(70, 300, 50);

        start_phase(20000, 74, 0);
        queue_random_requests(70, 3000, 50);

        start_phase(-1, 0, 74);
        jump_time_base(3'd1);
        queue_random_requests(40, 500, 40);

        start_phase(777_777, 7, 7);
        jump_time_base(3'd2);
        queue_random_requests(70, 60000, 50);

        // output held off for a long stretch while requests keep coming
        start_phase(5000, 0, 0);
        jump_time_base(3'd3);
        queue_random_requests(60, 800, 80);
        hold_start = hold_count;
        stall_go   = 1'b1;
        while (hold_count - hold_start < HoldCycles) @(negedge i_clk);
        stall_go   = 1'b0;

        // sender pauses until every lookup has returned
        start_phase(1, 0, 74);
        jump_time_base(3'd4);
        queue_random_requests(30, 3, 50);
        wait_for_results();
        queue_random_requests(30, 3, 50);

        // long run of mostly records
        start_phase(40000, 7, 7);
        jump_time_base(3'd5);
        queue_random_requests(50, 100, 4);

        start_phase(DelayMax, 74, 0);
        jump_time_base(3'd6);
        queue_random_requests(40, 400000, 60);

        start_phase(-DelayMax, 0, 0);
        jump_time_base(3'd7);
        queue_random_requests(20, 1000, 50);
        queue_random_pose(OP_LOOKUP, TimeMax);

        start_phase(DelayMax, 0, 0);
        queue_random_pose(OP_LOOKUP, TimeMax);
        queue_pose(OP_RECORD, TimeMax, 32'h7fffffff, 32'h80000000, -1,
                   -16384, 16384, -16384, 16384);
        queue_random_pose(OP_LOOKUP, TimeMax);
        start_phase(0, 0, 0);
        queue_random_pose(OP_LOOKUP, TimeMax);

        drain_and_settle();
        if (expected_lookups.size() != 0) begin
            report_mismatch($sformatf("%0d lookups never returned", expected_lookups.size()));
        end
        $display("Run covered %0d requests (%0d records, ring depth %0d), %0d lookup results",
                 requests_taken, records_taken, HistDepth, results_seen);
        $display("Status mix: empty %0d, future %0d, newest %0d, oldest %0d, span %0d",
                 status_seen[ST_EMPTY], status_seen[ST_FUTURE], status_seen[ST_NEWEST],
                 status_seen[ST_OLDEST], status_seen[ST_SPAN]);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
